// ----- design/deq_pkg.sv -----
// Package with the shared codes and types of the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

    // Widths of the transaction fields.
    localparam int MODE_W   = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    // Operation codes carried by the mode field.
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_REAR  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_REAR   = 3'd3,
        MODE_LIST       = 3'd4
    } mode_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Commands from the controller to the datapath, one per cycle.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_PUSH_FRONT,
        CMD_PUSH_REAR,
        CMD_POP_FRONT,
        CMD_POP_REAR,
        CMD_LIST_FIRST,
        CMD_LIST_NEXT,
        CMD_REPORT_EMPTY,
        CMD_REPORT_FULL
    } cmd_t;

    // Status flags from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic occ_one;
        logic cursor_last;
    } deq_stat_t;

endpackage

// ----- design/deq_ctrl.sv -----
// Controller state machine of the double-ended queue.
`timescale 1ns / 1ps

module deq_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [deq_pkg::MODE_W-1:0] mode,
    input  deq_pkg::deq_stat_t         stat,
    output deq_pkg::cmd_t              cmd,
    output logic                       busy
);
    import deq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_LIST
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    always_comb
    begin
        cmd        = CMD_NONE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (mode_t'(mode))
                        MODE_PUSH_FRONT: cmd = stat.full ? CMD_REPORT_FULL : CMD_PUSH_FRONT;
                        MODE_PUSH_REAR:  cmd = stat.full ? CMD_REPORT_FULL : CMD_PUSH_REAR;
                        MODE_POP_FRONT:  cmd = stat.empty ? CMD_REPORT_EMPTY : CMD_POP_FRONT;
                        MODE_POP_REAR:   cmd = stat.empty ? CMD_REPORT_EMPTY : CMD_POP_REAR;
                        MODE_LIST:
                        begin
                            if (stat.empty)
                            begin
                                cmd = CMD_REPORT_EMPTY;
                            end
                            else
                            begin
                                cmd = CMD_LIST_FIRST;
                                if (!stat.occ_one)
                                begin
                                    state_next = S_LIST;
                                end
                            end
                        end
                        default: cmd = CMD_NONE;
                    endcase
                end
            end
            S_LIST:
            begin
                cmd = CMD_LIST_NEXT;
                if (stat.cursor_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        busy_next = (state_next == S_LIST);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

// ----- design/deq_dpath.sv -----
// Datapath of the double-ended queue: ring memory, pointers and result registers.
`timescale 1ns / 1ps

module deq_dpath #(
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  deq_pkg::cmd_t                       cmd,
    input  logic signed [deq_pkg::WORD_W-1:0]   value,
    output deq_pkg::deq_stat_t                  stat,
    output logic                                strobe,
    output logic signed [deq_pkg::WORD_W-1:0]   word,
    output logic [deq_pkg::STATUS_W-1:0]        status,
    output logic                                last
);
    import deq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [WORD_W-1:0]   mem [DEPTH];
    logic [WORD_W-1:0]   rd_data_reg;
    logic [PTR_W-1:0]    head_reg;
    logic [PTR_W-1:0]    head_next;
    logic [CNT_W-1:0]    occ_reg;
    logic [CNT_W-1:0]    occ_next;
    logic [PTR_W-1:0]    cursor_reg;
    logic [PTR_W-1:0]    cursor_next;
    logic                strobe_reg;
    logic                from_mem_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                last_reg;

    logic [PTR_W-1:0]    head_dec;
    logic [PTR_W-1:0]    head_inc;
    logic [SUM_W-1:0]    rear_sum;
    logic [SUM_W-1:0]    rear_wrap;
    logic [PTR_W-1:0]    rear_pos;
    logic [CNT_W-1:0]    rd_off;
    logic [SUM_W-1:0]    rd_sum;
    logic [SUM_W-1:0]    rd_wrap;
    logic [PTR_W-1:0]    rd_addr;
    logic [PTR_W-1:0]    wr_addr;
    logic                wr_en;
    logic                rd_en;

    // Ring arithmetic: sums stay below twice the depth, so one subtract wraps them.
    assign head_dec  = (head_reg == '0) ? PTR_W'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc  = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign rear_sum  = SUM_W'(head_reg) + SUM_W'(occ_reg);
    assign rear_wrap = (rear_sum >= SUM_W'(DEPTH)) ? rear_sum - SUM_W'(DEPTH) : rear_sum;
    assign rear_pos  = rear_wrap[PTR_W-1:0];

    always_comb
    begin
        if (cmd == CMD_POP_REAR)
        begin
            rd_off = occ_reg - 1'b1;
        end
        else if (cmd == CMD_LIST_NEXT)
        begin
            rd_off = CNT_W'(cursor_reg);
        end
        else
        begin
            rd_off = '0;
        end
    end

    assign rd_sum  = SUM_W'(head_reg) + SUM_W'(rd_off);
    assign rd_wrap = (rd_sum >= SUM_W'(DEPTH)) ? rd_sum - SUM_W'(DEPTH) : rd_sum;
    assign rd_addr = rd_wrap[PTR_W-1:0];

    assign wr_en   = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_REAR);
    assign wr_addr = (cmd == CMD_PUSH_FRONT) ? head_dec : rear_pos;
    assign rd_en   = (cmd == CMD_POP_FRONT) || (cmd == CMD_POP_REAR)
                  || (cmd == CMD_LIST_FIRST) || (cmd == CMD_LIST_NEXT);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        head_next   = head_reg;
        occ_next    = occ_reg;
        cursor_next = cursor_reg;
        unique case (cmd)
            CMD_PUSH_FRONT:
            begin
                head_next = head_dec;
                occ_next  = occ_reg + 1'b1;
            end
            CMD_PUSH_REAR:  occ_next = occ_reg + 1'b1;
            CMD_POP_FRONT:
            begin
                head_next = head_inc;
                occ_next  = occ_reg - 1'b1;
            end
            CMD_POP_REAR:   occ_next = occ_reg - 1'b1;
            CMD_LIST_FIRST: cursor_next = PTR_W'(1);
            CMD_LIST_NEXT:  cursor_next = cursor_reg + 1'b1;
            default:        cursor_next = cursor_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            occ_reg    <= '0;
            cursor_reg <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            occ_reg    <= occ_next;
            cursor_reg <= cursor_next;
            strobe_reg <= (cmd != CMD_NONE);
        end
    end

    always_ff @(posedge clk)
    begin
        from_mem_reg <= rd_en;
        unique case (cmd)
            CMD_REPORT_EMPTY: status_reg <= ST_EMPTY;
            CMD_REPORT_FULL:  status_reg <= ST_FULL;
            default:          status_reg <= ST_OK;
        endcase
        if (cmd == CMD_LIST_FIRST)
        begin
            last_reg <= stat.occ_one;
        end
        else if (cmd == CMD_LIST_NEXT)
        begin
            last_reg <= stat.cursor_last;
        end
        else
        begin
            last_reg <= 1'b1;
        end
    end

    assign stat.empty       = (occ_reg == '0);
    assign stat.full        = (occ_reg == CNT_W'(DEPTH));
    assign stat.occ_one     = (occ_reg == CNT_W'(1));
    assign stat.cursor_last = (CNT_W'(cursor_reg) == occ_reg - 1'b1);

    assign strobe = strobe_reg;
    assign word   = from_mem_reg ? rd_data_reg : '0;
    assign status = status_reg;
    assign last   = last_reg;

endmodule

// ----- design/double_ended_queue.sv -----
// Top level of the bounded double-ended queue of signed 32-bit words.
`timescale 1ns / 1ps

// Usage
// A transaction is accepted at a rising edge where start is high and busy is low.
// mode selects push front, push rear, pop front, pop rear or list all; value is
// the word to push and is ignored otherwise. Unused mode codes are taken and
// dropped without any result.
// Each result appears for exactly one cycle with strobe high: word, status and
// last. The receiver cannot stall, so results are never held back.
// Pushes and pops give their single result in the cycle after acceptance and
// leave busy low, so one such transaction may be accepted in every cycle.
// A list reads one stored entry per cycle from the single read port of the ring
// memory, front to rear: with N words stored it gives N results on successive
// cycles from the cycle after acceptance, and busy stays high until the last one.
// Last is set on the final result. An empty list, a pop from an empty queue
// and a push to a full queue each give one result with a status code.
// Reset clears the head pointer, the occupancy and the list walk; the memory
// contents are not cleared and need no clearing pass, since only stored words
// are ever read.
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [deq_pkg::MODE_W-1:0]          mode,
    input  logic signed [deq_pkg::WORD_W-1:0]   value,
    output logic                                strobe,
    output logic signed [deq_pkg::WORD_W-1:0]   word,
    output logic [deq_pkg::STATUS_W-1:0]        status,
    output logic                                last
);
    import deq_pkg::*;

    // Command issued this cycle and the flags that steer the controller.
    cmd_t      cmd;
    deq_stat_t stat;

    // The controller turns each accepted transaction into one command, or a list into a
    // first list command and a run of further list commands while busy is high.
    deq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // The datapath holds the ring, its pointers and the registered result.
    deq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .value  (value),
        .stat   (stat),
        .strobe (strobe),
        .word   (word),
        .status (status),
        .last   (last)
    );

endmodule

// ----- design/deq_checker.sv -----
// Port-level checker of the double-ended queue and its bind to the top level.
`timescale 1ns / 1ps

module deq_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic [deq_pkg::MODE_W-1:0]          mode,
    input logic                                strobe,
    input logic signed [deq_pkg::WORD_W-1:0]   word,
    input logic [deq_pkg::STATUS_W-1:0]        status,
    input logic                                last
);
    import deq_pkg::*;

    // A push or pop transaction gives its only result in the next cycle.
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode == MODE_PUSH_FRONT || mode == MODE_PUSH_REAR
            || mode == MODE_POP_FRONT || mode == MODE_POP_REAR)) |=> (strobe && last))
        else $error("push or pop did not give a single final result");

    // An unused mode code gives no result.
    a_unused_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode > MODE_LIST) |=> !strobe)
        else $error("unused mode gave a result");

    // Error results carry a zero word and end the transaction.
    a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && status != ST_OK) |-> (word == '0 && last))
        else $error("error result with data or without last");

    // A list walk runs without gaps until its last result.
    a_list_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> strobe)
        else $error("gap in list results");

    // The end of a list walk coincides with its last result.
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (strobe && last))
        else $error("busy dropped without final result");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .mode   (mode),
    .strobe (strobe),
    .word   (word),
    .status (status),
    .last   (last)
);
